/* design/pcm_pkg.sv */
// shared types and constants of the priority command mux with ramp
// no dependencies; imported by every other file of the block but pcm_fifo
package pcm_pkg;

  localparam int NUM_INPUTS   = 4;
  localparam int SRC_SLOTS    = 4;
  localparam int SRC_IDX_BITS = 2;
  localparam int CMD_BITS     = 16;
  localparam int PRIO_BITS    = 16;
  localparam int TICK_BITS    = 16;
  localparam int AUTH_BITS    = 17;
  localparam int FRAC_BITS    = 16;
  localparam int WIN_BITS     = 3;
  localparam int CFG_BITS     = 17;
  localparam int CFG_IDX_BITS = 3;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [WIN_BITS-1:0]  NO_WINNER = WIN_BITS'(4);
  localparam logic [AUTH_BITS-1:0] FULL_AUTH = AUTH_BITS'(65536);
  localparam logic [SRC_SLOTS-1:0] USED_MASK = SRC_SLOTS'((1 << NUM_INPUTS) - 1);

  localparam logic [TICK_BITS-1:0] RAMP_TICKS_RST = TICK_BITS'(30);
  localparam logic [AUTH_BITS-1:0] RAMP_STEP_RST  = AUTH_BITS'(2185);

  localparam logic [CFG_IDX_BITS-1:0] REG_PRIO_A      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRIO_B      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRIO_C      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRIO_D      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_EMERG_FWD   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_EMERG_STEER = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_TICKS  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_STEP   = 3'd7;

  typedef struct packed {
    logic signed [CMD_BITS-1:0] fwd_a;
    logic signed [CMD_BITS-1:0] fwd_b;
    logic signed [CMD_BITS-1:0] fwd_c;
    logic signed [CMD_BITS-1:0] fwd_d;
    logic signed [CMD_BITS-1:0] steer_a;
    logic signed [CMD_BITS-1:0] steer_b;
    logic signed [CMD_BITS-1:0] steer_c;
    logic signed [CMD_BITS-1:0] steer_d;
    logic [SRC_SLOTS-1:0]       eligible_mask;
    logic [SRC_SLOTS-1:0]       trip_mask;
  } in_t;

  typedef struct packed {
    logic signed [CMD_BITS-1:0] out_forward;
    logic signed [CMD_BITS-1:0] out_steering;
    logic [WIN_BITS-1:0]        source;
    logic                       ramping;
  } out_t;

  typedef struct packed {
    logic [SRC_SLOTS-1:0][PRIO_BITS-1:0] prio;
    logic signed [CMD_BITS-1:0]          emerg_fwd;
    logic signed [CMD_BITS-1:0]          emerg_steer;
    logic [TICK_BITS-1:0]                ramp_ticks;
    logic [AUTH_BITS-1:0]                ramp_step;
  } cfg_t;

  typedef struct packed {
    logic [WIN_BITS-1:0]        winner;
    logic signed [CMD_BITS-1:0] tgt_fwd;
    logic signed [CMD_BITS-1:0] tgt_steer;
  } mid_t;

endpackage

/* design/pcm_fifo.sv */
// small first-word-fall-through queue used between the stages and at the output
// depends on nothing but its parameters
module pcm_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/pcm_front.sv */
// front stage: trip and eligibility check, priority arbitration, target select
// depends on pcm_pkg
module pcm_front (
  input  pcm_pkg::in_t  in_i,
  input  pcm_pkg::cfg_t cfg_i,
  output pcm_pkg::mid_t mid_o
);
  import pcm_pkg::*;

  logic signed [CMD_BITS-1:0]  fwd_v   [SRC_SLOTS];
  logic signed [CMD_BITS-1:0]  steer_v [SRC_SLOTS];
  logic [SRC_SLOTS-1:0]        elig, trip;
  logic [WIN_BITS-1:0]         win;
  logic signed [PRIO_BITS-1:0] best;

  always_comb begin
    fwd_v[0]   = in_i.fwd_a;
    fwd_v[1]   = in_i.fwd_b;
    fwd_v[2]   = in_i.fwd_c;
    fwd_v[3]   = in_i.fwd_d;
    steer_v[0] = in_i.steer_a;
    steer_v[1] = in_i.steer_b;
    steer_v[2] = in_i.steer_c;
    steer_v[3] = in_i.steer_d;
    elig = in_i.eligible_mask & USED_MASK;
    trip = in_i.trip_mask & USED_MASK;
    win  = NO_WINNER;
    best = '0;
    // ascending scan with strict compare keeps the lowest index on a tie
    if (trip == '0) begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
        if (elig[i] && ((win == NO_WINNER) || ($signed(cfg_i.prio[i]) > best))) begin
          win  = WIN_BITS'(i);
          best = $signed(cfg_i.prio[i]);
        end
      end
    end
    mid_o.winner = win;
    if (win == NO_WINNER) begin
      mid_o.tgt_fwd   = cfg_i.emerg_fwd;
      mid_o.tgt_steer = cfg_i.emerg_steer;
    end else begin
      mid_o.tgt_fwd   = fwd_v[win[SRC_IDX_BITS-1:0]];
      mid_o.tgt_steer = steer_v[win[SRC_IDX_BITS-1:0]];
    end
  end

endmodule

/* design/pcm_back.sv */
// back stage: handover state, authority ramp and linear blend of the output
// depends on pcm_pkg
module pcm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcm_pkg::cfg_t cfg_i,
  input  logic          fire_i,
  input  pcm_pkg::mid_t item_i,
  output pcm_pkg::out_t res_o
);
  import pcm_pkg::*;

  localparam int ProdW = CMD_BITS + AUTH_BITS + 2;

  function automatic logic signed [CMD_BITS-1:0] blend(
    input logic signed [CMD_BITS-1:0] start,
    input logic signed [CMD_BITS-1:0] target,
    input logic [AUTH_BITS-1:0]       auth
  );
    logic signed [CMD_BITS:0]  diff;
    logic signed [ProdW-1:0]   prod;
    logic signed [ProdW-1:0]   shifted;
    logic signed [CMD_BITS:0]  sum;
    diff    = (CMD_BITS+1)'(target) - (CMD_BITS+1)'(start);
    prod    = diff * $signed({1'b0, auth});
    // arithmetic shift floors toward minus infinity
    shifted = prod >>> FRAC_BITS;
    sum     = (CMD_BITS+1)'(start) + shifted[CMD_BITS:0];
    return sum[CMD_BITS-1:0];
  endfunction

  logic signed [CMD_BITS-1:0] last_fwd_q, last_fwd_d, last_steer_q, last_steer_d;
  logic signed [CMD_BITS-1:0] start_fwd_q, start_fwd_d, start_steer_q, start_steer_d;
  logic [WIN_BITS-1:0]        prior_q, prior_d;
  logic                       handover_q, handover_d;
  logic [TICK_BITS-1:0]       cnt_q, cnt_d;
  logic [AUTH_BITS-1:0]       auth_q, auth_d;

  logic                       emerg, start_new, ho;
  logic signed [CMD_BITS-1:0] sf, ss, of, os;
  logic [TICK_BITS-1:0]       cnt;
  logic [AUTH_BITS-1:0]       auth;
  logic [AUTH_BITS:0]         auth_sum;

  always_comb begin
    emerg     = (item_i.winner == NO_WINNER);
    start_new = !emerg && (cfg_i.ramp_ticks != '0) && (prior_q != NO_WINNER) &&
                (item_i.winner != prior_q);
    ho        = !emerg && (start_new || handover_q);
    sf        = start_new ? last_fwd_q : start_fwd_q;
    ss        = start_new ? last_steer_q : start_steer_q;
    cnt       = start_new ? '0 : cnt_q;
    auth      = start_new ? '0 : auth_q;
    auth_sum  = {1'b0, auth} + {1'b0, cfg_i.ramp_step};

    if (ho) begin
      of = blend(sf, item_i.tgt_fwd, auth);
      os = blend(ss, item_i.tgt_steer, auth);
    end else begin
      of = item_i.tgt_fwd;
      os = item_i.tgt_steer;
    end

    res_o.out_forward  = of;
    res_o.out_steering = os;
    res_o.source       = item_i.winner;
    res_o.ramping      = ho;

    last_fwd_d    = of;
    last_steer_d  = os;
    start_fwd_d   = sf;
    start_steer_d = ss;
    prior_d       = item_i.winner;
    handover_d    = ho;
    cnt_d         = cnt;
    auth_d        = auth;
    if (ho) begin
      if (cnt >= cfg_i.ramp_ticks) begin
        handover_d = 1'b0;
      end else begin
        cnt_d  = cnt + TICK_BITS'(1);
        auth_d = (auth_sum > {1'b0, FULL_AUTH}) ? FULL_AUTH : auth_sum[AUTH_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_fwd_q   <= '0;
      last_steer_q <= '0;
      prior_q      <= NO_WINNER;
      handover_q   <= 1'b0;
      cnt_q        <= '0;
      auth_q       <= '0;
    end else if (fire_i) begin
      last_fwd_q   <= last_fwd_d;
      last_steer_q <= last_steer_d;
      prior_q      <= prior_d;
      handover_q   <= handover_d;
      cnt_q        <= cnt_d;
      auth_q       <= auth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      start_fwd_q   <= start_fwd_d;
      start_steer_q <= start_steer_d;
    end
  end

endmodule

/* design/priority_command_mux_with_ramp.sv */
// top level of the priority command mux with handover ramp
// depends on pcm_pkg, pcm_fifo, pcm_front and pcm_back
//
// usage: each control tick is one transaction pushed on the input queue
// (push, full): per-source forward and steering commands plus eligible and
// trip masks. one result transaction per tick leaves on the output queue
// (empty, pop): the command sent, the winning source (4 = emergency) and
// whether the output was blended during a handover.
// configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
// the user must write it only while no transaction is in flight, since the
// block itself does not enforce this. a pushed transaction is written to the
// middle queue, is processed by the back stage once the output queue has
// room, and is then written to the output queue, from which it is popped.
// throughput: one transaction per cycle unless the output queue is full; the
// back stage's blend (one multiply per channel) and state update set it.
// reset: config takes its reset values, no winner is remembered, no ramp
// runs and both queues are empty. a stalled receiver fills the output queue,
// then the middle queue, and full rises; no transaction is lost.
module priority_command_mux_with_ramp #(
  parameter int QueueDepth = pcm_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  pcm_pkg::in_t                         in_data_i,
  output logic                                 empty,
  input  logic                                 pop,
  output pcm_pkg::out_t                        out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [pcm_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [pcm_pkg::CFG_BITS-1:0]         cfg_data_i
);
  import pcm_pkg::*;

  cfg_t cfg_q;
  mid_t front_mid, back_mid;
  out_t back_res;
  logic mid_empty, out_full, back_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prio        <= '0;
      cfg_q.emerg_fwd   <= '0;
      cfg_q.emerg_steer <= '0;
      cfg_q.ramp_ticks  <= RAMP_TICKS_RST;
      cfg_q.ramp_step   <= RAMP_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PRIO_A:      cfg_q.prio[0]     <= cfg_data_i[PRIO_BITS-1:0];
        REG_PRIO_B:      cfg_q.prio[1]     <= cfg_data_i[PRIO_BITS-1:0];
        REG_PRIO_C:      cfg_q.prio[2]     <= cfg_data_i[PRIO_BITS-1:0];
        REG_PRIO_D:      cfg_q.prio[3]     <= cfg_data_i[PRIO_BITS-1:0];
        REG_EMERG_FWD:   cfg_q.emerg_fwd   <= cfg_data_i[CMD_BITS-1:0];
        REG_EMERG_STEER: cfg_q.emerg_steer <= cfg_data_i[CMD_BITS-1:0];
        REG_RAMP_TICKS:  cfg_q.ramp_ticks  <= cfg_data_i[TICK_BITS-1:0];
        REG_RAMP_STEP:   cfg_q.ramp_step   <= cfg_data_i[AUTH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  pcm_front u_front (
    .in_i  (in_data_i),
    .cfg_i (cfg_q),
    .mid_o (front_mid)
  );

  pcm_fifo #(
    .Width ($bits(mid_t)),
    .Depth (QueueDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_mid),
    .full_o  (full),
    .pop_i   (back_fire),
    .data_o  (back_mid),
    .empty_o (mid_empty)
  );

  assign back_fire = !mid_empty && !out_full;

  pcm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .fire_i (back_fire),
    .item_i (back_mid),
    .res_o  (back_res)
  );

  pcm_fifo #(
    .Width ($bits(out_t)),
    .Depth (QueueDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_fire),
    .data_i  (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule

/* dv/cmd_tracker_pkg.sv */
// scoreboard class for the priority command mux with handover ramp
// depends on pcm_pkg; imported by tb_priority_command_mux_with_ramp
package cmd_tracker_pkg;
  import pcm_pkg::*;

  class cmd_tracker;
    logic signed [PRIO_BITS-1:0] prio [SRC_SLOTS];
    logic signed [CMD_BITS-1:0]  emerg_fwd;
    logic signed [CMD_BITS-1:0]  emerg_steer;
    logic [TICK_BITS-1:0]        ramp_ticks;
    logic [AUTH_BITS-1:0]        ramp_step;

    logic signed [CMD_BITS-1:0]  last_fwd;
    logic signed [CMD_BITS-1:0]  last_steer;
    logic signed [CMD_BITS-1:0]  start_fwd;
    logic signed [CMD_BITS-1:0]  start_steer;
    logic [WIN_BITS-1:0]         prev_winner;
    bit                          handover;
    logic [TICK_BITS-1:0]        ramp_count;
    logic [AUTH_BITS-1:0]        authority;

    out_t expected_cmd_q [$];
    int   n_done;
    int   errors;

    function new();
      foreach (prio[i]) prio[i] = '0;
      emerg_fwd   = '0;
      emerg_steer = '0;
      ramp_ticks  = RAMP_TICKS_RST;
      ramp_step   = RAMP_STEP_RST;
      last_fwd    = '0;
      last_steer  = '0;
      start_fwd   = '0;
      start_steer = '0;
      prev_winner = NO_WINNER;
      handover    = 1'b0;
      ramp_count  = '0;
      authority   = '0;
      n_done      = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
      case (idx)
        REG_PRIO_A, REG_PRIO_B, REG_PRIO_C, REG_PRIO_D:
          prio[idx[SRC_IDX_BITS-1:0]] = data[PRIO_BITS-1:0];
        REG_EMERG_FWD:   emerg_fwd   = data[CMD_BITS-1:0];
        REG_EMERG_STEER: emerg_steer = data[CMD_BITS-1:0];
        REG_RAMP_TICKS:  ramp_ticks  = data[TICK_BITS-1:0];
        REG_RAMP_STEP:   ramp_step   = data[AUTH_BITS-1:0];
        default: ;
      endcase
    endfunction

    // origin + floor((goal - origin) * auth / 2^16)
    function logic signed [CMD_BITS-1:0] blend(logic signed [CMD_BITS-1:0] origin,
                                               logic signed [CMD_BITS-1:0] goal,
                                               logic [AUTH_BITS-1:0] auth);
      longint span;
      longint prod;
      span = longint'(goal) - longint'(origin);
      prod = span * longint'(auth);
      return CMD_BITS'(longint'(origin) + (prod >>> FRAC_BITS));
    endfunction

    function void note_tick(in_t t);
      logic [SRC_SLOTS-1:0]        elig;
      logic [SRC_SLOTS-1:0]        trip;
      logic signed [CMD_BITS-1:0]  fwd [SRC_SLOTS];
      logic signed [CMD_BITS-1:0]  steer [SRC_SLOTS];
      logic [WIN_BITS-1:0]         win;
      logic signed [PRIO_BITS-1:0] best;
      logic [AUTH_BITS:0]          next_auth;
      out_t                        r;
      elig  = t.eligible_mask & USED_MASK;
      trip  = t.trip_mask & USED_MASK;
      fwd   = '{t.fwd_a, t.fwd_b, t.fwd_c, t.fwd_d};
      steer = '{t.steer_a, t.steer_b, t.steer_c, t.steer_d};
      win   = NO_WINNER;
      best  = '0;
      if (trip == '0) begin
        for (int i = 0; i < NUM_INPUTS; i++) begin
          if (elig[i] && (win == NO_WINNER || prio[i] > best)) begin
            win  = WIN_BITS'(i);
            best = prio[i];
          end
        end
      end
      r.source  = win;
      r.ramping = 1'b0;
      if (win == NO_WINNER) begin
        r.out_forward  = emerg_fwd;
        r.out_steering = emerg_steer;
        prev_winner    = NO_WINNER;
        handover       = 1'b0;
      end else begin
        if (ramp_ticks != '0 && prev_winner != NO_WINNER && win != prev_winner) begin
          start_fwd   = last_fwd;
          start_steer = last_steer;
          ramp_count  = '0;
          authority   = '0;
          handover    = 1'b1;
        end
        prev_winner = win;
        if (handover) begin
          r.out_forward  = blend(start_fwd, fwd[win[SRC_IDX_BITS-1:0]], authority);
          r.out_steering = blend(start_steer, steer[win[SRC_IDX_BITS-1:0]], authority);
          r.ramping      = 1'b1;
          if (ramp_count >= ramp_ticks) begin
            handover = 1'b0;
          end else begin
            next_auth  = authority + ramp_step;
            ramp_count = ramp_count + 1'b1;
            authority  = (next_auth > FULL_AUTH) ? FULL_AUTH : next_auth[AUTH_BITS-1:0];
          end
        end else begin
          r.out_forward  = fwd[win[SRC_IDX_BITS-1:0]];
          r.out_steering = steer[win[SRC_IDX_BITS-1:0]];
        end
      end
      last_fwd   = r.out_forward;
      last_steer = r.out_steering;
      expected_cmd_q = {expected_cmd_q, r};
    endfunction

    function void check_cmd(out_t got);
      out_t exp_cmd;
      if (expected_cmd_q.size() == 0) begin
        $error("unexpected result transaction: out_forward %0d, source %0d",
               got.out_forward, got.source);
        errors++;
        return;
      end
      exp_cmd = expected_cmd_q.pop_front();
      n_done++;
      if (got.out_forward !== exp_cmd.out_forward) begin
        $error("out_forward: expected %0d, got %0d", exp_cmd.out_forward, got.out_forward);
        errors++;
      end
      if (got.out_steering !== exp_cmd.out_steering) begin
        $error("out_steering: expected %0d, got %0d", exp_cmd.out_steering, got.out_steering);
        errors++;
      end
      if (got.source !== exp_cmd.source) begin
        $error("source: expected %0d, got %0d", exp_cmd.source, got.source);
        errors++;
      end
      if (got.ramping !== exp_cmd.ramping) begin
        $error("ramping: expected %0d, got %0d", exp_cmd.ramping, got.ramping);
        errors++;
      end
    endfunction
  endclass

endpackage

/* dv/tb_priority_command_mux_with_ramp.sv */
// testbench for priority_command_mux_with_ramp: directed and random ticks
// under several register settings, checked against cmd_tracker
// depends on pcm_pkg, cmd_tracker_pkg and the design files
module tb_priority_command_mux_with_ramp;
  timeunit 1ns;
  timeprecision 1ps;
  import pcm_pkg::*;
  import cmd_tracker_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    push = 1'b0;
  logic                    full;
  in_t                     in_data_i = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  out_t                    out_data_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [CFG_BITS-1:0]     cfg_data_i = '0;

  cmd_tracker          tracker;
  logic [CFG_BITS-1:0] reg_vals [8];
  int                  send_idle_pct = 32;
  int                  pop_idle_pct = 65;
  int                  n_sent = 0;
  int                  stall_cycles = 0;

  priority_command_mux_with_ramp dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) stall_cycles = 0;
      else stall_cycles++;
      if (push && !full) tracker.note_tick(in_data_i);
      if (pop && !empty) tracker.check_cmd(out_data_o);
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [CMD_BITS-1:0] rand_cmd();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      default: return CMD_BITS'($urandom);
    endcase
  endfunction

  function automatic in_t rand_tick(logic [SRC_SLOTS-1:0] elig, logic [SRC_SLOTS-1:0] trip);
    in_t t;
    t.fwd_a         = rand_cmd();
    t.fwd_b         = rand_cmd();
    t.fwd_c         = rand_cmd();
    t.fwd_d         = rand_cmd();
    t.steer_a       = rand_cmd();
    t.steer_b       = rand_cmd();
    t.steer_c       = rand_cmd();
    t.steer_d       = rand_cmd();
    t.eligible_mask = elig;
    t.trip_mask     = trip;
    return t;
  endfunction

  function automatic in_t extreme_tick(logic [SRC_SLOTS-1:0] elig, bit hi);
    in_t t;
    {t.fwd_a, t.fwd_b, t.fwd_c, t.fwd_d}         = {4{hi ? 16'h7FFF : 16'h8000}};
    {t.steer_a, t.steer_b, t.steer_c, t.steer_d} = {4{hi ? 16'h8000 : 16'h7FFF}};
    t.eligible_mask = elig;
    t.trip_mask     = '0;
    return t;
  endfunction

  function automatic logic [CFG_BITS-1:0] rand_prio();
    case ($urandom_range(5))
      0: return 17'h08000;
      1: return 17'h07FFF;
      2: return '0;
      3: return 17'h00001;
      default: return CFG_BITS'($urandom);
    endcase
  endfunction

  function automatic void pick_settings(int phase);
    int ticks;
    for (int i = 0; i < SRC_SLOTS; i++) reg_vals[REG_PRIO_A + i] = rand_prio();
    reg_vals[REG_EMERG_FWD]   = CFG_BITS'($urandom);
    reg_vals[REG_EMERG_STEER] = CFG_BITS'($urandom);
    case (phase)
      0: begin
        ticks = $urandom_range(8, 1);
        reg_vals[REG_RAMP_STEP] = CFG_BITS'(65536 / ticks);
      end
      1: begin
        ticks = 65535;
        reg_vals[REG_RAMP_STEP] = CFG_BITS'($urandom_range(40));
      end
      2: begin
        ticks = 0;
        reg_vals[REG_RAMP_STEP] = CFG_BITS'($urandom);
      end
      3: begin
        ticks = $urandom_range(6, 1);
        reg_vals[REG_RAMP_STEP] = CFG_BITS'($urandom_range(131071));
      end
      4: begin
        ticks = 1;
        reg_vals[REG_RAMP_STEP] = CFG_BITS'(65536);
      end
      default: begin
        ticks = $urandom_range(65535, 1);
        reg_vals[REG_RAMP_STEP] = CFG_BITS'(65536 / ticks);
      end
    endcase
    reg_vals[REG_RAMP_TICKS] = CFG_BITS'(ticks);
  endfunction

  task automatic send_tick(input in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (full);
    n_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (tracker.n_done < n_sent) @(posedge clk_i);
  endtask

  task automatic apply_settings();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_BITS'(i);
      cfg_data_i <= reg_vals[i];
      @(posedge clk_i);
      tracker.write_reg(CFG_IDX_BITS'(i), reg_vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int count);
    logic [SRC_SLOTS-1:0] elig;
    logic [SRC_SLOTS-1:0] trip;
    int                   hold;
    hold = 0;
    elig = '0;
    repeat (count) begin
      if (hold == 0) begin
        case ($urandom_range(9))
          0: elig = '0;
          1, 2, 3: elig = SRC_SLOTS'(1 << $urandom_range(SRC_SLOTS-1));
          default: elig = SRC_SLOTS'($urandom);
        endcase
        hold = $urandom_range(12, 1);
      end
      hold--;
      trip = ($urandom_range(19) == 0) ? SRC_SLOTS'($urandom_range(15, 1)) : '0;
      send_tick(rand_tick(elig, trip));
    end
  endtask

  initial begin
    tracker = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: all priorities equal, 30 tick ramp
    send_tick(rand_tick(4'b1111, 4'b0000));
    send_tick(rand_tick(4'b0010, 4'b0000));
    send_tick(rand_tick(4'b0010, 4'b0000));
    send_tick(rand_tick(4'b0000, 4'b0000));
    for (int i = 0; i < SRC_SLOTS; i++) send_tick(rand_tick(4'b1111, SRC_SLOTS'(1 << i)));
    send_tick(rand_tick(4'b1111, 4'b1111));

    // extreme priorities and commands, short ramp with oversized step
    drain();
    reg_vals[REG_PRIO_A]      = 17'h18000;
    reg_vals[REG_PRIO_B]      = 17'h07FFF;
    reg_vals[REG_PRIO_C]      = 17'h17FFF;
    reg_vals[REG_PRIO_D]      = 17'h00000;
    reg_vals[REG_EMERG_FWD]   = 17'h08000;
    reg_vals[REG_EMERG_STEER] = 17'h07FFF;
    reg_vals[REG_RAMP_TICKS]  = 17'd3;
    reg_vals[REG_RAMP_STEP]   = 17'h1FFFF;
    apply_settings();
    send_tick(extreme_tick(4'b1111, 1'b0));
    send_tick(extreme_tick(4'b0101, 1'b1));
    send_tick(extreme_tick(4'b0101, 1'b1));
    send_tick(extreme_tick(4'b0001, 1'b0));
    for (int i = 0; i < 4; i++) send_tick(extreme_tick(4'b0001, i[0]));
    send_tick(rand_tick(4'b0001, 4'b0000));

    // longest ramp with zero step holds the start value
    drain();
    reg_vals[REG_RAMP_TICKS] = 17'd65535;
    reg_vals[REG_RAMP_STEP]  = 17'd0;
    apply_settings();
    repeat (3) send_tick(rand_tick(4'b1000, 4'b0000));

    // ramp disabled while a handover runs
    drain();
    reg_vals[REG_RAMP_TICKS] = 17'd0;
    apply_settings();
    send_tick(rand_tick(4'b1000, 4'b0000));
    send_tick(rand_tick(4'b1000, 4'b0000));
    send_tick(rand_tick(4'b0010, 4'b0000));

    for (int p = 0; p < 6; p++) begin
      drain();
      send_idle_pct = (p < 2) ? 32 : (p < 4) ? 65 : 0;
      pop_idle_pct  = (p < 2) ? 65 : (p < 4) ? 32 : 0;
      pick_settings(p);
      apply_settings();
      run_random(84);
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_cmd_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
